>>> src/crc16_checked_frame_parser_core_macros.svh
// Assertion macros shared by the frame parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CRC16_CHECKED_FRAME_PARSER_CORE_MACROS_SVH
`define CRC16_CHECKED_FRAME_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CFP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cfp assertion failed");
`define CFP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cfp assertion failed");
`else
`define CFP_ASSERT(label, clk, rst, prop)
`define CFP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> src/cfp_pkg.sv
// Shared types, constants and the byte-wise CRC-16/CCITT-FALSE update.
// No dependencies; imported by cfp_parser and the core top level.
package cfp_pkg;

  localparam logic [7:0]  HEAD_BYTE_RESET = 8'h55;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        frame_done;
    logic        frame_ok;
    logic [7:0]  frame_id;
    logic [7:0]  frame_length;
    logic [15:0] received_check;
  } result_t;

  // MSB-first CRC update over one byte.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> src/crc16_checked_frame_parser_core.sv
// Top level of the CRC-16 checked frame parser: input register, parser, output register.
// Depends on cfp_pkg and cfp_parser.
//
// Usage:
//   Input channel: in_valid / in_stall with rx_byte. A byte transfers at a rising
//   edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with the result fields. Every input byte
//   gives exactly one result, in order.
//   Configuration: cfg_wr_en / cfg_wr_data write head_byte; write only while idle.
// Path: a transferred byte is captured in the input register, stepped through the parser
//   and registered in the output register once the output side is free; out_valid then
//   rises and the result transfers when out_stall is low.
// Throughput: one byte per cycle while the output side is not stalled; the parser does a
//   byte-wise CRC update and phase step combinationally between the two registers.
// Reset (rst, synchronous): both stages empty, parser back to hunting, CRC at
//   0xFFFF, head_byte 0x55.
// Stall: while out_stall holds a pending result, the input register fills and then
//   in_stall rises; no byte is dropped and the output payload holds steady.
module crc16_checked_frame_parser_core
  import cfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic        frame_done,
  output logic        frame_ok,
  output logic [7:0]  frame_id,
  output logic [7:0]  frame_length,
  output logic [15:0] received_check
);

  logic [7:0] head_reg;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s2_load;
  logic       step;
  result_t    res;
  result_t    out_res;

  assign s2_load  = !out_valid || !out_stall;
  assign step     = s1_valid && s2_load;
  assign in_stall = s1_valid && !s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_reg <= HEAD_BYTE_RESET;
    end else if (cfg_wr_en) begin
      head_reg <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  cfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (s1_byte),
    .head_byte (head_reg),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign payload_valid  = out_res.payload_valid;
  assign payload_byte   = out_res.payload_byte;
  assign payload_index  = out_res.payload_index;
  assign frame_done     = out_res.frame_done;
  assign frame_ok       = out_res.frame_ok;
  assign frame_id       = out_res.frame_id;
  assign frame_length   = out_res.frame_length;
  assign received_check = out_res.received_check;

endmodule

>>> src/cfp_parser.sv
// Frame state machine: hunts for the head byte, tracks id/length/payload and
// checks the trailing CRC. Depends on cfp_pkg and the assertion macro header.
`include "crc16_checked_frame_parser_core_macros.svh"

module cfp_parser
  import cfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic [7:0] head_byte,
  output result_t    res
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ID   = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CKLO = 3'd4;
  localparam logic [2:0] PH_CKHI = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_id, held_id_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  check_low, check_low_next;
  logic [15:0] crc_upd;
  logic [15:0] got;
  logic [7:0]  count_inc;

  assign crc_upd   = crc_step(running_crc, rx_byte);
  assign got       = {rx_byte, check_low};
  assign count_inc = byte_count + 8'd1;

  always_comb begin
    phase_next       = phase;
    running_crc_next = running_crc;
    held_id_next     = held_id;
    held_length_next = held_length;
    byte_count_next  = byte_count;
    check_low_next   = check_low;
    res              = '0;
    unique case (phase)
      PH_ID: begin
        held_id_next     = rx_byte;
        running_crc_next = crc_upd;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        held_length_next = rx_byte;
        byte_count_next  = '0;
        running_crc_next = crc_upd;
        phase_next       = (rx_byte == 8'd0) ? PH_CKLO : PH_DATA;
      end
      PH_DATA: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = byte_count;
        running_crc_next  = crc_upd;
        byte_count_next   = count_inc;
        if (count_inc >= held_length) begin
          phase_next = PH_CKLO;
        end
      end
      PH_CKLO: begin
        check_low_next = rx_byte;
        phase_next     = PH_CKHI;
      end
      PH_CKHI: begin
        res.frame_done     = 1'b1;
        res.frame_ok       = (got == running_crc);
        res.received_check = got;
        phase_next         = PH_HUNT;
      end
      default: begin
        // unused codes fall back to hunting
        phase_next = PH_HUNT;
        if (rx_byte == head_byte) begin
          running_crc_next = crc_step(CRC_INIT, rx_byte);
          phase_next       = PH_ID;
        end
      end
    endcase
    res.frame_id     = held_id_next;
    res.frame_length = held_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_crc <= CRC_INIT;
      held_id     <= '0;
      held_length <= '0;
      byte_count  <= '0;
      check_low   <= '0;
    end else if (step) begin
      phase       <= phase_next;
      running_crc <= running_crc_next;
      held_id     <= held_id_next;
      held_length <= held_length_next;
      byte_count  <= byte_count_next;
      check_low   <= check_low_next;
    end
  end

  `CFP_ASSERT(a_data_count_in_range, clk, rst, (phase == PH_DATA) |-> (byte_count < held_length))
  `CFP_ASSERT(a_cklo_to_ckhi, clk, rst, (step && phase == PH_CKLO) |=> (phase == PH_CKHI))
  `CFP_ASSERT(a_ok_needs_done, clk, rst, res.frame_ok |-> res.frame_done)
  `CFP_ASSERT_ALWAYS(a_payload_not_done, clk, !(res.payload_valid && res.frame_done))

endmodule
